FILE: rtl/tamc_pkg.sv
// Package for the three-axis min/max calibrator.
// Holds field widths, reset values, register indexes and axis lane numbers.
// No dependencies.
package tamc_pkg;

	localparam int SAMPLE_BITS_DEF = 16;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int IDLE_W    = 16;
	localparam int OFS_W     = 17;
	localparam int SCALE_W   = 32;

	localparam logic [CFG_W-1:0] IDLE_LIMIT_RESET = 16'd10000;
	localparam logic [CFG_W-1:0] LED_HOLD_RESET   = 16'd100;

	localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LED_HOLD   = 1'd1;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	localparam int NUM_AXES = 3;
	localparam int AX_X     = 0;
	localparam int AX_Y     = 1;
	localparam int AX_Z     = 2;

endpackage

FILE: rtl/three_axis_min_max_calibrator.sv
// Top level of the three-axis min/max calibrator: extreme tracking, idle timer,
// and three bit-serial restoring dividers for the per-axis scale.
// Depends on tamc_pkg.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------------------
//  cfg      | in        | cfg_we               | cfg_index, cfg_data
//  in       | in        | in_valid / in_stall  | req_type, raw_a, raw_b, raw_c
//  out      | out       | out_valid / out_stall| offset_*_half, scale_*, changed, led_on,
//           |           |                      | done_res
//
// A tick or a sample that moves no extreme goes from acceptance straight to the
// load state. A sample that moves an extreme first runs the dividers, which
// rebuild the scales one quotient bit per cycle.
// Reset clears all extremes, the idle timer, the LED and done, and loads the
// register reset values. A stalled result holds; the next item is taken while
// it waits, and its result is loaded once the waiting one has been taken.
module three_axis_min_max_calibrator #(
	parameter int SAMPLE_BITS = tamc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic        [tamc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [tamc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 req_type,
	input  logic signed [SAMPLE_BITS-1:0]        raw_a,
	input  logic signed [SAMPLE_BITS-1:0]        raw_b,
	input  logic signed [SAMPLE_BITS-1:0]        raw_c,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [tamc_pkg::OFS_W-1:0]     offset_x_half,
	output logic signed [tamc_pkg::OFS_W-1:0]     offset_y_half,
	output logic signed [tamc_pkg::OFS_W-1:0]     offset_z_half,
	output logic        [tamc_pkg::SCALE_W-1:0]   scale_x,
	output logic        [tamc_pkg::SCALE_W-1:0]   scale_y,
	output logic        [tamc_pkg::SCALE_W-1:0]   scale_z,
	output logic                                 changed,
	output logic                                 led_on,
	output logic                                 done_res
);
	import tamc_pkg::*;

	localparam int AW    = SAMPLE_BITS + 1;
	localparam int RW    = SAMPLE_BITS + 2;
	localparam int EW    = AW + OFS_W + 1;
	localparam int QW    = SCALE_W + 1;
	localparam int CNT_W = $clog2(QW);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	logic [1:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [AW-1:0]    max_q [NUM_AXES];
	logic signed [AW-1:0]    min_q [NUM_AXES];
	logic [RW-1:0]           rem_q [NUM_AXES];
	logic [QW-1:0]           quo_q [NUM_AXES];
	logic [SCALE_W-1:0]      scale_q [NUM_AXES];
	logic [IDLE_W-1:0]       idle_q;
	logic [CFG_W-1:0]        idle_limit_q;
	logic [CFG_W-1:0]        led_hold_q;
	logic                    led_q;
	logic                    fin_q;
	logic                    chg_q;
	logic                    out_valid_q;
	logic signed [OFS_W-1:0] ofs_out_q [NUM_AXES];
	logic [SCALE_W-1:0]      scale_out_q [NUM_AXES];
	logic                    chg_out_q;
	logic                    led_out_q;
	logic                    fin_out_q;

	logic                    in_acc;
	logic signed [AW-1:0]    samp [NUM_AXES];
	logic signed [AW-1:0]    max_n [NUM_AXES];
	logic signed [AW-1:0]    min_n [NUM_AXES];
	logic                    chg_n;
	logic [IDLE_W-1:0]       idle_n;
	logic                    led_n;
	logic                    fin_n;
	logic                    do_chk;
	logic [AW-1:0]           span [NUM_AXES];
	logic [RW-1:0]           trial [NUM_AXES];
	logic                    ge [NUM_AXES];
	logic [RW-1:0]           rem_n [NUM_AXES];
	logic [QW-1:0]           quo_n [NUM_AXES];
	logic signed [EW-1:0]    osum [NUM_AXES];
	logic                    dbit;
	logic                    div_last;
	logic                    load_go;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign dbit     = (cnt_q == '0);
	assign div_last = (cnt_q == CNT_W'(QW - 1));
	assign load_go  = (state_q == ST_LOAD) && (!out_valid_q || !out_stall);

	// The third sensor word is the negated x axis.
	assign samp[AX_X] = -AW'(raw_c);
	assign samp[AX_Y] = AW'(raw_a);
	assign samp[AX_Z] = AW'(raw_b);

	always_comb begin
		chg_n  = 1'b0;
		idle_n = idle_q;
		led_n  = led_q;
		fin_n  = fin_q;
		do_chk = 1'b0;
		for (int i = 0; i < NUM_AXES; i++) begin
			max_n[i] = max_q[i];
			min_n[i] = min_q[i];
		end
		if (req_type == REQ_TICK) begin
			if (idle_q != '1) begin
				idle_n = idle_q + 1'b1;
			end
			do_chk = 1'b1;
		end else if (!fin_q) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				if (samp[i] > max_q[i]) begin
					max_n[i] = samp[i];
					chg_n    = 1'b1;
				end else if (samp[i] < min_q[i]) begin
					min_n[i] = samp[i];
					chg_n    = 1'b1;
				end
			end
			if (chg_n) begin
				led_n  = 1'b1;
				idle_n = '0;
			end else begin
				do_chk = 1'b1;
			end
		end
		if (do_chk) begin
			if (idle_n > led_hold_q) begin
				led_n = 1'b0;
			end
			if (idle_n >= idle_limit_q) begin
				fin_n = 1'b1;
			end
		end
	end

	// One restoring step per axis and cycle; the dividend is 2^32, so only the
	// first step shifts in a one. A set bit 32 of the quotient means saturation,
	// which also covers a zero span.
	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			span[i]  = AW'(max_q[i] - min_q[i]);
			trial[i] = {rem_q[i][RW-2:0], dbit};
			ge[i]    = (trial[i] >= {1'b0, span[i]});
			rem_n[i] = ge[i] ? (trial[i] - {1'b0, span[i]}) : trial[i];
			quo_n[i] = {quo_q[i][QW-2:0], ge[i]};
			osum[i]  = -(EW'(max_q[i]) + EW'(min_q[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			idle_q       <= '0;
			idle_limit_q <= IDLE_LIMIT_RESET;
			led_hold_q   <= LED_HOLD_RESET;
			led_q        <= 1'b0;
			fin_q        <= 1'b0;
			chg_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < NUM_AXES; i++) begin
				max_q[i]   <= '0;
				min_q[i]   <= '0;
				scale_q[i] <= '1;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IDLE_LIMIT: idle_limit_q <= cfg_data;
					REG_LED_HOLD:   led_hold_q   <= cfg_data;
					default:        ;
				endcase
			end
			// A result taken in the cycle that loads the next one stays valid.
			if (out_valid_q && !out_stall && !load_go) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						idle_q <= idle_n;
						led_q  <= led_n;
						fin_q  <= fin_n;
						chg_q  <= chg_n;
						for (int i = 0; i < NUM_AXES; i++) begin
							max_q[i] <= max_n[i];
							min_q[i] <= min_n[i];
						end
						cnt_q   <= '0;
						state_q <= chg_n ? ST_DIV : ST_LOAD;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (div_last) begin
						for (int i = 0; i < NUM_AXES; i++) begin
							scale_q[i] <= quo_n[i][QW-1] ? '1 : quo_n[i][SCALE_W-1:0];
						end
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (load_go) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Divider datapath and the result register carry no reset.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				rem_q[i] <= '0;
				quo_q[i] <= '0;
			end
		end else if (state_q == ST_DIV) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				rem_q[i] <= rem_n[i];
				quo_q[i] <= quo_n[i];
			end
		end
		if (load_go) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				ofs_out_q[i]   <= osum[i][OFS_W-1:0];
				scale_out_q[i] <= scale_q[i];
			end
			chg_out_q <= chg_q;
			led_out_q <= led_q;
			fin_out_q <= fin_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign offset_x_half = ofs_out_q[AX_X];
	assign offset_y_half = ofs_out_q[AX_Y];
	assign offset_z_half = ofs_out_q[AX_Z];
	assign scale_x       = scale_out_q[AX_X];
	assign scale_y       = scale_out_q[AX_Y];
	assign scale_z       = scale_out_q[AX_Z];
	assign changed       = chg_out_q;
	assign led_on        = led_out_q;
	assign done_res      = fin_out_q;

	// Once finished, calibration stays finished.
	a_fin_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> fin_q)
		else $error("done flag dropped after being set");

	// A sample taken after done leaves the x maximum and y minimum alone and reports no change.
	a_ignore_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (req_type == REQ_SAMPLE) && fin_q) |=>
		($stable(max_q[AX_X]) && $stable(min_q[AX_Y]) && !chg_q))
		else $error("sample after done altered the state");

	// The extremes start at zero, so the max never goes negative and the min
	// never goes positive.
	a_extreme_sign: assert property (@(posedge clk) disable iff (!arst_n)
		!max_q[AX_Z][AW-1] && (min_q[AX_Z][AW-1] || (min_q[AX_Z] == '0)))
		else $error("axis extreme crossed zero");

	// A result is only ever loaded out of the load state.
	a_load_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_LOAD))
		else $error("result valid raised outside the load state");

	// The divider never runs past its last quotient bit.
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q <= CNT_W'(QW - 1)))
		else $error("divider step count overran");

endmodule
